// ===== rtl/belt_surface_contact_query_assert.svh =====
// Assertion macros for the belt surface contact query block
`ifndef BELT_SURFACE_CONTACT_QUERY_ASSERT_SVH
`define BELT_SURFACE_CONTACT_QUERY_ASSERT_SVH

`ifndef SYNTHESIS
`define BSCQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BSCQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BSCQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BSCQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/bscq_pkg.sv =====
`default_nettype none
package bscq_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int DIR_FRAC_BITS_DEF   = 14;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FORWARD_VECTOR = 3'd0,
      CSR_NORMAL_VECTOR  = 3'd1,
      CSR_ORIGIN_X       = 3'd2,
      CSR_ORIGIN_Y       = 3'd3,
      CSR_ORIGIN_Z       = 3'd4,
      CSR_HALF_LENGTH    = 3'd5,
      CSR_HALF_WIDTH     = 3'd6
   } csr_index_type;

   localparam logic signed [31:0] INT32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] contact_x;
      logic signed [31:0] contact_y;
      logic signed [31:0] contact_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] elevation;
      logic signed [15:0] surface_normal_x;
      logic signed [15:0] surface_normal_y;
      logic signed [15:0] surface_normal_z;
      logic               off_surface;
      logic               divide_fault;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== rtl/bscq_stream_if.sv =====
`default_nettype none
interface bscq_stream_if #(
   parameter type word_type = logic
) ();
   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/bscq_div.sv =====
`default_nettype none
module bscq_div #(
   parameter int NW = 8,
   parameter int DW = 8,
   parameter int TW = 1
) (
   input  wire           clock,
   input  wire           reset,
   input  wire           advance,
   input  wire           in_valid,
   input  wire  [NW-1:0] num_a,
   input  wire  [NW-1:0] num_b,
   input  wire  [DW-1:0] den,
   input  wire  [TW-1:0] tag_in,
   output logic          out_valid,
   output logic [NW-1:0] quo_a,
   output logic [NW-1:0] quo_b,
   output logic [TW-1:0] tag_out
);
   logic          valid_ff [NW+1];
   logic [DW-1:0] rem_a_ff [NW+1];
   logic [DW-1:0] rem_b_ff [NW+1];
   logic [NW-1:0] sh_a_ff  [NW+1];
   logic [NW-1:0] sh_b_ff  [NW+1];
   logic [TW-1:0] tag_ff   [NW+1];
   logic [DW:0]   trial_a  [NW+1];
   logic [DW:0]   trial_b  [NW+1];
   logic          hit_a    [NW+1];
   logic          hit_b    [NW+1];

   always_comb begin
      trial_a[0] = '0;
      trial_b[0] = '0;
      hit_a[0]   = 1'b0;
      hit_b[0]   = 1'b0;
      for (int k = 1; k <= NW; k++) begin
         trial_a[k] = {rem_a_ff[k-1], sh_a_ff[k-1][NW-1]};
         trial_b[k] = {rem_b_ff[k-1], sh_b_ff[k-1][NW-1]};
         hit_a[k]   = trial_a[k] >= {1'b0, den};
         hit_b[k]   = trial_b[k] >= {1'b0, den};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k <= NW; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_a_ff[0] <= '0;
         rem_b_ff[0] <= '0;
         sh_a_ff[0]  <= num_a;
         sh_b_ff[0]  <= num_b;
         tag_ff[0]   <= tag_in;
         for (int k = 1; k <= NW; k++) begin
            rem_a_ff[k] <= hit_a[k] ? DW'(trial_a[k] - {1'b0, den}) : DW'(trial_a[k]);
            rem_b_ff[k] <= hit_b[k] ? DW'(trial_b[k] - {1'b0, den}) : DW'(trial_b[k]);
            sh_a_ff[k]  <= {sh_a_ff[k-1][NW-2:0], hit_a[k]};
            sh_b_ff[k]  <= {sh_b_ff[k-1][NW-2:0], hit_b[k]};
            tag_ff[k]   <= tag_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[NW];
   assign quo_a     = sh_a_ff[NW];
   assign quo_b     = sh_b_ff[NW];
   assign tag_out   = tag_ff[NW];
endmodule
`default_nettype wire

// ===== rtl/belt_surface_contact_query.sv =====
// Belt surface contact query. Takes one contact point word per cycle and returns one
// result word per point, in order. The pipeline depth is set by the bit-serial pipelined
// divider that drops the point onto the belt plane, one quotient bit per stage; its quotient
// width is NW = 2 * max(34 - DIR_FRAC_BITS, 16) + 36 - DIR_FRAC_BITS, so 62 bits at the
// default DIR_FRAC_BITS of 14.
// A new point enters every cycle; the whole pipeline holds while a result waits on
// rsp_stream. After a register write, let the ground level settle through side_ff, gp_ff and
// gq_ff, corner_ff, cmin_ff and ground_ff before the first point.
`default_nettype none
`include "belt_surface_contact_query_assert.svh"
module belt_surface_contact_query import bscq_pkg::*; #(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int DIR_FRAC_BITS   = DIR_FRAC_BITS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_write_enable,
   input  wire [CSR_INDEX_W-1:0] csr_index,
   input  wire [CSR_DATA_W-1:0]  csr_write_data,
   bscq_stream_if.sink           req_stream,
   bscq_stream_if.source         rsp_stream
);
   localparam int F    = DIR_FRAC_BITS;
   localparam int SW   = 34 - F;
   localparam int SXW  = (SW > 16) ? SW : 16;
   localparam int PW   = SXW + 33;
   localparam int AW   = PW + 2;
   localparam int LW   = AW + 1 - F;
   localparam int LOW  = LW / 2;
   localparam int HIW  = LW - LOW;
   localparam int PLW  = LOW + 1 + SXW;
   localparam int PHW  = HIW + SXW;
   localparam int NW   = LW + SXW;
   localparam int UW   = NW + 2;
   localparam int EW   = SXW + 33;
   localparam int GW   = 32 + SXW;
   localparam int CW   = GW + 3;
   localparam int TW   = 2 + 2 * LW;

   localparam logic signed [33:0]   RND_S = 34'(1) <<< (F - 1);
   localparam logic signed [AW:0]   RND_A = (AW + 1)'(1) <<< (F - 1);
   localparam logic signed [EW+1:0] RND_E = (EW + 2)'(1) <<< (F - 1);
   localparam logic signed [CW-1:0] RND_G = CW'(1) <<< (F - 1);
   localparam logic signed [15:0] NORMAL_ONE =
      (F >= 15) ? 16'sh7fff : 16'(1 << F);

   // configuration registers
   logic        [47:0] forward_ff, normal_ff;
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic        [30:0] half_length_ff, half_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_ff     <= 48'(1) << F;
         normal_ff      <= (48'(1) << F) << 32;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         half_length_ff <= 31'(1) << COORD_FRAC_BITS;
         half_width_ff  <= 31'(1) << COORD_FRAC_BITS;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_FORWARD_VECTOR: forward_ff     <= csr_write_data;
            CSR_NORMAL_VECTOR:  normal_ff      <= csr_write_data;
            CSR_ORIGIN_X:       origin_x_ff    <= csr_write_data[31:0];
            CSR_ORIGIN_Y:       origin_y_ff    <= csr_write_data[31:0];
            CSR_ORIGIN_Z:       origin_z_ff    <= csr_write_data[31:0];
            CSR_HALF_LENGTH:    half_length_ff <= csr_write_data[30:0];
            CSR_HALF_WIDTH:     half_width_ff  <= csr_write_data[30:0];
            default: begin
            end
         endcase
      end
   end

   logic signed [15:0] f_vec [3];
   logic signed [15:0] n_vec [3];
   logic signed [31:0] hl_s, hw_s;
   logic               fault;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_vec[i] = forward_ff[16*i +: 16];
         n_vec[i] = normal_ff[16*i +: 16];
      end
      hl_s  = $signed({1'b0, half_length_ff});
      hw_s  = $signed({1'b0, half_width_ff});
      fault = n_vec[2] == 16'sd0;
   end

   // side = normal x forward
   logic signed [32:0]   cross_raw [3];
   logic signed [SW-1:0] side_ff   [3];

   always_comb begin
      cross_raw[0] = 33'(32'(n_vec[1]) * 32'(f_vec[2])) - 33'(32'(n_vec[2]) * 32'(f_vec[1]));
      cross_raw[1] = 33'(32'(n_vec[2]) * 32'(f_vec[0])) - 33'(32'(n_vec[0]) * 32'(f_vec[2]));
      cross_raw[2] = 33'(32'(n_vec[0]) * 32'(f_vec[1])) - 33'(32'(n_vec[1]) * 32'(f_vec[0]));
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) side_ff[i] <= SW'((34'(cross_raw[i]) + RND_S) >>> F);
   end

   // ground level, free running from the registers
   logic signed [GW-1:0] gp_ff, gq_ff;
   logic signed [CW-1:0] corner_ff [4];
   logic signed [CW-1:0] corner_in [4];
   logic signed [CW-1:0] cmin_ff;
   logic signed [CW-1:0] min_lo, min_hi;
   logic signed [CW:0]   ground_raw;
   logic signed [31:0]   ground_ff;

   always_comb begin
      corner_in[0] = CW'(origin_z_ff) + ((-CW'(gp_ff) - CW'(gq_ff) + RND_G) >>> F);
      corner_in[1] = CW'(origin_z_ff) + ((-CW'(gp_ff) + CW'(gq_ff) + RND_G) >>> F);
      corner_in[2] = CW'(origin_z_ff) + ((CW'(gp_ff) - CW'(gq_ff) + RND_G) >>> F);
      corner_in[3] = CW'(origin_z_ff) + ((CW'(gp_ff) + CW'(gq_ff) + RND_G) >>> F);
      min_lo = (corner_ff[0] < corner_ff[1]) ? corner_ff[0] : corner_ff[1];
      min_hi = (corner_ff[2] < corner_ff[3]) ? corner_ff[2] : corner_ff[3];
      ground_raw = (CW + 1)'(cmin_ff) - ((CW + 1)'(hl_s) + (CW + 1)'(hw_s));
   end

   always_ff @(posedge clock) begin
      gp_ff <= GW'(hl_s) * GW'(f_vec[2]);
      gq_ff <= GW'(hw_s) * GW'(side_ff[2]);
      for (int k = 0; k < 4; k++) corner_ff[k] <= corner_in[k];
      cmin_ff <= (min_lo < min_hi) ? min_lo : min_hi;
      if (ground_raw > (CW + 1)'(INT32_MAX))      ground_ff <= INT32_MAX;
      else if (ground_raw < (CW + 1)'(INT32_MIN)) ground_ff <= INT32_MIN;
      else                                        ground_ff <= 32'(ground_raw);
   end

   // point pipeline
   logic rsp_valid_ff;
   logic advance;
   assign advance          = !rsp_valid_ff || rsp_stream.ready;
   assign req_stream.ready = advance && !reset;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s6_valid_ff, s7_valid_ff;
   logic signed [32:0]    d_ff  [3];
   logic signed [PW-1:0]  fd_ff [3];
   logic signed [PW-1:0]  sd_ff [3];
   logic signed [PW-1:0]  nd_ff [3];
   logic signed [LW-1:0]  lx3_ff, ly3_ff, lz3_ff, lx4_ff, ly4_ff, lx5_ff, ly5_ff;
   logic signed [PHW-1:0] pf_hi_ff, ps_hi_ff;
   logic signed [PLW-1:0] pf_lo_ff, ps_lo_ff;
   logic signed [NW-1:0]  num_f_ff, num_s_ff;
   logic signed [31:0]    u6_ff, v6_ff;
   logic                  off6_ff, off7_ff;
   logic signed [EW-1:0]  eu_ff, ev_ff;
   rsp_word_type          rsp_word_ff;

   logic signed [AW-1:0]  ax_in, ay_in, az_in;
   logic signed [LOW:0]   lz_lo;
   logic signed [HIW-1:0] lz_hi;
   logic                  neg_f, neg_s;
   logic [NW-1:0]         mag_f, mag_s;
   logic [15:0]           den_mag;

   always_comb begin
      ax_in = AW'(fd_ff[0]) + AW'(fd_ff[1]) + AW'(fd_ff[2]);
      ay_in = AW'(sd_ff[0]) + AW'(sd_ff[1]) + AW'(sd_ff[2]);
      az_in = AW'(nd_ff[0]) + AW'(nd_ff[1]) + AW'(nd_ff[2]);
      lz_lo = $signed({1'b0, lz3_ff[LOW-1:0]});
      lz_hi = lz3_ff[LW-1:LOW];
      neg_f = num_f_ff[NW-1] ^ n_vec[2][15];
      neg_s = num_s_ff[NW-1] ^ n_vec[2][15];
      mag_f = num_f_ff[NW-1] ? NW'(-num_f_ff) : NW'(num_f_ff);
      mag_s = num_s_ff[NW-1] ? NW'(-num_s_ff) : NW'(num_s_ff);
      den_mag = n_vec[2][15] ? 16'(-n_vec[2]) : 16'(n_vec[2]);
      if (fault) den_mag = 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_stream.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff[0] <= 33'(req_stream.payload.contact_x) - 33'(origin_x_ff);
         d_ff[1] <= 33'(req_stream.payload.contact_y) - 33'(origin_y_ff);
         d_ff[2] <= 33'(req_stream.payload.contact_z) - 33'(origin_z_ff);
         for (int i = 0; i < 3; i++) begin
            fd_ff[i] <= PW'(f_vec[i]) * PW'(d_ff[i]);
            sd_ff[i] <= PW'(side_ff[i]) * PW'(d_ff[i]);
            nd_ff[i] <= PW'(n_vec[i]) * PW'(d_ff[i]);
         end
         lx3_ff   <= LW'(((AW + 1)'(ax_in) + RND_A) >>> F);
         ly3_ff   <= LW'(((AW + 1)'(ay_in) + RND_A) >>> F);
         lz3_ff   <= LW'(((AW + 1)'(az_in) + RND_A) >>> F);
         pf_hi_ff <= PHW'(lz_hi) * PHW'(f_vec[2]);
         ps_hi_ff <= PHW'(lz_hi) * PHW'(side_ff[2]);
         pf_lo_ff <= PLW'(lz_lo) * PLW'(f_vec[2]);
         ps_lo_ff <= PLW'(lz_lo) * PLW'(side_ff[2]);
         lx4_ff   <= lx3_ff;
         ly4_ff   <= ly3_ff;
         num_f_ff <= (NW'(pf_hi_ff) <<< LOW) + NW'(pf_lo_ff);
         num_s_ff <= (NW'(ps_hi_ff) <<< LOW) + NW'(ps_lo_ff);
         lx5_ff   <= lx4_ff;
         ly5_ff   <= ly4_ff;
      end
   end

   logic          div_valid;
   logic [NW-1:0] quo_f, quo_s;
   logic [TW-1:0] div_tag;

   bscq_div #(
      .NW (NW),
      .DW (16),
      .TW (TW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s5_valid_ff),
      .num_a     (mag_f),
      .num_b     (mag_s),
      .den       (den_mag),
      .tag_in    ({neg_f, neg_s, lx5_ff, ly5_ff}),
      .out_valid (div_valid),
      .quo_a     (quo_f),
      .quo_b     (quo_s),
      .tag_out   (div_tag)
   );

   logic signed [NW:0]     q_f, q_s;
   logic signed [UW-1:0]   u_in, v_in, hl_u, hw_u;
   logic                   off_in;
   logic signed [EW+1:0]   esum, etot;
   logic signed [31:0]     elev_sat;
   logic                   off_final;

   always_comb begin
      q_f = div_tag[TW-1] ? -$signed({1'b0, quo_f}) : $signed({1'b0, quo_f});
      q_s = div_tag[TW-2] ? -$signed({1'b0, quo_s}) : $signed({1'b0, quo_s});
      u_in = UW'($signed(div_tag[2*LW-1:LW])) - UW'(q_f);
      v_in = UW'($signed(div_tag[LW-1:0])) - UW'(q_s);
      hl_u = UW'(hl_s);
      hw_u = UW'(hw_s);
      off_in = (u_in < -hl_u) || (u_in > hl_u) || (v_in < -hw_u) || (v_in > hw_u);
      esum = (((EW + 2)'(eu_ff) + (EW + 2)'(ev_ff)) + RND_E) >>> F;
      etot = esum + (EW + 2)'(origin_z_ff);
      if (etot > (EW + 2)'(INT32_MAX))      elev_sat = INT32_MAX;
      else if (etot < (EW + 2)'(INT32_MIN)) elev_sat = INT32_MIN;
      else                                  elev_sat = 32'(etot);
      off_final = fault || off7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff  <= div_valid;
         s7_valid_ff  <= s6_valid_ff;
         rsp_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u6_ff   <= u_in[31:0];
         v6_ff   <= v_in[31:0];
         off6_ff <= off_in;
         eu_ff   <= EW'(f_vec[2]) * EW'(u6_ff);
         ev_ff   <= EW'(side_ff[2]) * EW'(v6_ff);
         off7_ff <= off6_ff;
         rsp_word_ff.elevation        <= off_final ? ground_ff : elev_sat;
         rsp_word_ff.surface_normal_x <= off_final ? 16'sd0 : n_vec[0];
         rsp_word_ff.surface_normal_y <= off_final ? 16'sd0 : n_vec[1];
         rsp_word_ff.surface_normal_z <= off_final ? NORMAL_ONE : n_vec[2];
         rsp_word_ff.off_surface      <= off_final;
         rsp_word_ff.divide_fault     <= fault;
      end
   end

   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_word_ff;

   `BSCQ_ASSERT_IMPL(a_fault_is_off, clock, reset, rsp_stream.valid && rsp_stream.payload.divide_fault, rsp_stream.payload.off_surface)
   `BSCQ_ASSERT_IMPL(a_off_normal_up, clock, reset, rsp_stream.valid && rsp_stream.payload.off_surface, rsp_stream.payload.surface_normal_x == 16'sd0 && rsp_stream.payload.surface_normal_y == 16'sd0 && rsp_stream.payload.surface_normal_z == NORMAL_ONE)
   `BSCQ_ASSERT_IMPL(a_stall_blocks_req, clock, reset, rsp_stream.valid && !rsp_stream.ready, !req_stream.ready)
   `BSCQ_ASSERT_NEXT(a_accept_enters, clock, reset, req_stream.valid && req_stream.ready, s1_valid_ff)
endmodule
`default_nettype wire
